### rtl/pli_pkg.sv
// Shared constants and types for the piecewise linear interpolator.
// Used by pli_div and piecewise_linear_interpolator_core; no dependencies.
package pli_pkg;

	// Fraction bits of the fixed-point format and of the blend coefficient.
	localparam int FRAC_W = 16;

	// Fixed widths of the stream fields.
	localparam int IDX_W = 6;
	localparam int CNT_W = 7;
	localparam int FIELD_W = 32;

	// Input word layout, lowest bit first.
	localparam int IDX_LSB = 0;
	localparam int LIN_LSB = IDX_LSB + IDX_W;
	localparam int LOUT_LSB = LIN_LSB + FIELD_W;
	localparam int SMP_LSB = LOUT_LSB + FIELD_W;
	localparam int IN_DATA_W = ((SMP_LSB + FIELD_W + 7) / 8) * 8;
	localparam int OUT_DATA_W = FIELD_W;

	// Item kinds carried in the input tuser.
	localparam logic ACT_WRITE = 1'b0;
	localparam logic ACT_EVAL = 1'b1;

	// Pipeline control handed to the divider.
	typedef struct packed {
		logic en;
		logic valid;
	} pli_ctl_t;

endpackage

### rtl/pli_div.sv
// Pipelined restoring divider producing a FRAC_W-bit quotient, one bit per stage.
// Depends on pli_pkg for FRAC_W and the control struct.
module pli_div
	import pli_pkg::*;
#(
	parameter int VB = 32,
	parameter int PW = 66
) (
	input  logic          clk,
	input  logic          arst_n,
	input  pli_ctl_t      ctl,
	input  logic [VB-1:0] rem_in,
	input  logic [VB-1:0] den_in,
	input  logic [PW-1:0] pay_in,
	output logic          vld_out,
	output logic [FRAC_W-1:0] quo_out,
	output logic [PW-1:0] pay_out
);

	logic [VB-1:0]     rem_s [FRAC_W];
	logic [VB-1:0]     den_s [FRAC_W];
	logic [FRAC_W-1:0] quo_s [FRAC_W];
	logic [PW-1:0]     pay_s [FRAC_W];
	logic              vld_s [FRAC_W];

	for (genvar i = 0; i < FRAC_W; i++) begin : g_step
		logic [VB-1:0]     r_prev;
		logic [VB-1:0]     d_prev;
		logic [FRAC_W-1:0] q_prev;
		logic [PW-1:0]     p_prev;
		logic              v_prev;
		logic [VB:0]       t;
		logic [VB:0]       diff;
		logic              take;

		if (i == 0) begin : g_first
			assign r_prev = rem_in;
			assign d_prev = den_in;
			assign q_prev = '0;
			assign p_prev = pay_in;
			assign v_prev = ctl.valid;
		end else begin : g_next
			assign r_prev = rem_s[i-1];
			assign d_prev = den_s[i-1];
			assign q_prev = quo_s[i-1];
			assign p_prev = pay_s[i-1];
			assign v_prev = vld_s[i-1];
		end

		// Shift in one bit of the remainder and subtract the divisor if it fits.
		assign t = {r_prev, 1'b0};
		assign diff = t - {1'b0, d_prev};
		assign take = (t >= {1'b0, d_prev});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i] <= 1'b0;
			end else if (ctl.en) begin
				vld_s[i] <= v_prev;
			end
		end

		always_ff @(posedge clk) begin
			if (ctl.en) begin
				rem_s[i] <= take ? diff[VB-1:0] : t[VB-1:0];
				den_s[i] <= d_prev;
				quo_s[i] <= {q_prev[FRAC_W-2:0], take};
				pay_s[i] <= p_prev;
			end
		end
	end

	assign vld_out = vld_s[FRAC_W-1];
	assign quo_out = quo_s[FRAC_W-1];
	assign pay_out = pay_s[FRAC_W-1];

endmodule

### rtl/piecewise_linear_interpolator_core.sv
// Piecewise linear interpolator over a table of breakpoint pairs, top level.
// Throughput: one word per cycle while the output word is not held; the
// 16-stage quotient pipeline sets the depth.
// Reset clears all valid bits and sets the point count to 2; table contents
// are undefined until written and need no clearing pass.
// Depends on pli_pkg and pli_div.
module piecewise_linear_interpolator_core
	import pli_pkg::*;
#(
	parameter int MAX_POINTS = 64,
	parameter int VALUE_BITS = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// Configuration channel: point_count.
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CNT_W-1:0]      cfg_data,
	// Input stream. tdata: point_index, point_level_in, point_level_out, sample.
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,
	// tuser: action.
	input  logic [0:0]            s_axis_tuser,
	// Output stream. tdata: value.
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	output logic [OUT_DATA_W-1:0] m_axis_tdata,
	// tuser: no_segment.
	output logic [0:0]            m_axis_tuser
);

	localparam int VB = VALUE_BITS;
	localparam int IW = $clog2(MAX_POINTS);
	localparam int PW = 2 * VB + 2;
	localparam int MW = VB + FRAC_W + 1;

	// Levels are kept with the sign bit flipped, so that unsigned order matches
	// signed order throughout the table and the arithmetic.
	function automatic logic [VB-1:0] to_biased(input logic [FIELD_W-1:0] f);
		logic [VB+FIELD_W-1:0] e;
		e = {{VB{1'b0}}, f};
		to_biased = e[VB-1:0] ^ {1'b1, {(VB-1){1'b0}}};
	endfunction

	// Global advance: the whole pipeline moves unless the output word is held.
	logic en;
	logic acc_in;

	logic [IW-1:0] last_q;

	logic [VB-1:0]     in_lvl_q [MAX_POINTS];
	logic [2*VB-1:0]   pair_mem [MAX_POINTS];

	// Stage 1: registered input word and the row of compares.
	logic              v_s1;
	logic              act_s1;
	logic              slot_ok_s1;
	logic [IW-1:0]     waddr_s1;
	logic [VB-1:0]     wlin_s1;
	logic [VB-1:0]     wlout_s1;
	logic [VB-1:0]     smp_s1;
	logic [MAX_POINTS-1:0] lt_s1;

	// Stage 2: breakpoint pairs read from the table.
	logic              v_s2;
	logic [VB-1:0]     smp_s2;
	logic              zc_s2;
	logic              ns_s2;
	logic [2*VB-1:0]   rda_s2;
	logic [2*VB-1:0]   rdb_s2;

	// Stage 3: divider operands.
	logic              v_s3;
	logic [VB-1:0]     rem_s3;
	logic [VB-1:0]     den_s3;
	logic [PW-1:0]     pay_s3;

	// Stage 4: weighted products.
	logic              v_s4;
	logic              ns_s4;
	logic [MW-1:0]     p0_s4;
	logic [MW-1:0]     p1_s4;

	// Output register.
	logic              out_vld_q;
	logic [VB-1:0]     out_val_q;
	logic              out_ns_q;

	assign en = !out_vld_q || m_axis_tready;
	assign s_axis_tready = en;
	assign acc_in = s_axis_tvalid && en;
	assign cfg_ready = 1'b1;

	// The point count is stored already clamped, as the index of the last
	// breakpoint in use.
	logic [IW-1:0] last_next;
	always_comb begin
		int n;
		if (int'(cfg_data) < 2) begin
			n = 2;
		end else if (int'(cfg_data) > MAX_POINTS) begin
			n = MAX_POINTS;
		end else begin
			n = int'(cfg_data);
		end
		last_next = IW'(n - 1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q <= IW'(1);
		end else if (cfg_valid && cfg_ready) begin
			last_q <= last_next;
		end
	end

	// Input unpacking.
	logic [IDX_W-1:0]   f_index;
	logic [IW+IDX_W-1:0] f_index_ext;
	logic [VB-1:0]      smp_b;
	assign f_index = s_axis_tdata[IDX_LSB +: IDX_W];
	assign f_index_ext = {{IW{1'b0}}, f_index};
	assign smp_b = to_biased(s_axis_tdata[SMP_LSB +: FIELD_W]);

	// One compare per breakpoint. A write still waiting in stage 1 is forwarded
	// into its lane so that a sample behind it sees the new level.
	logic [MAX_POINTS-1:0] lt_in;
	always_comb begin
		for (int j = 0; j < MAX_POINTS; j++) begin
			if (v_s1 && act_s1 == ACT_WRITE && slot_ok_s1 && waddr_s1 == IW'(j)) begin
				lt_in[j] = smp_b < wlin_s1;
			end else begin
				lt_in[j] = smp_b < in_lvl_q[j];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= acc_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			act_s1 <= s_axis_tuser[0];
			slot_ok_s1 <= int'(f_index) < MAX_POINTS;
			waddr_s1 <= f_index_ext[IW-1:0];
			wlin_s1 <= to_biased(s_axis_tdata[LIN_LSB +: FIELD_W]);
			wlout_s1 <= to_biased(s_axis_tdata[LOUT_LSB +: FIELD_W]);
			smp_s1 <= smp_b;
			lt_s1 <= lt_in;
		end
	end

	// Stage 1 decode: the first breakpoint above the sample, or a clamp. A
	// clamp reads one pair on both ports and forces the coefficient to zero.
	logic          found;
	logic [IW-1:0] k;
	logic [IW-1:0] ra;
	logic [IW-1:0] rb;
	logic          zc;
	logic          ns;
	always_comb begin
		found = 1'b0;
		k = '0;
		for (int j = MAX_POINTS - 1; j >= 1; j--) begin
			if (lt_s1[j] && IW'(j) <= last_q) begin
				found = 1'b1;
				k = IW'(j);
			end
		end
		ns = 1'b0;
		zc = 1'b1;
		ra = '0;
		rb = '0;
		priority if (lt_s1[0]) begin
			ra = '0;
			rb = '0;
		end else if (!lt_s1[last_q]) begin
			ra = last_q;
			rb = last_q;
		end else if (found) begin
			ra = k - IW'(1);
			rb = k;
			zc = 1'b0;
		end else begin
			ns = 1'b1;
		end
	end

	// Writes land in the table as they leave stage 1, the same edge at which a
	// sample in stage 1 reads it, which keeps table access in word order.
	always_ff @(posedge clk) begin
		if (en) begin
			if (v_s1 && act_s1 == ACT_WRITE && slot_ok_s1) begin
				in_lvl_q[waddr_s1] <= wlin_s1;
				pair_mem[waddr_s1] <= {wlin_s1, wlout_s1};
			end
			rda_s2 <= pair_mem[ra];
			rdb_s2 <= pair_mem[rb];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1 && act_s1 == ACT_EVAL;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			smp_s2 <= smp_s1;
			zc_s2 <= zc;
			ns_s2 <= ns;
		end
	end

	// Stage 2: offset into the segment and the segment width.
	logic [VB-1:0] x0;
	logic [VB-1:0] x1;
	assign x0 = rda_s2[2*VB-1:VB];
	assign x1 = rdb_s2[2*VB-1:VB];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s3 <= smp_s2 - x0;
			den_s3 <= x1 - x0;
			pay_s3 <= {ns_s2, zc_s2, rdb_s2[VB-1:0], rda_s2[VB-1:0]};
		end
	end

	// The coefficient is (offset * 2^16) / width, truncated.
	pli_ctl_t            div_ctl;
	logic                div_vld;
	logic [FRAC_W-1:0]   div_quo;
	logic [PW-1:0]       div_pay;
	assign div_ctl.en = en;
	assign div_ctl.valid = v_s3;

	pli_div #(
		.VB(VB),
		.PW(PW)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (div_ctl),
		.rem_in (rem_s3),
		.den_in (den_s3),
		.pay_in (pay_s3),
		.vld_out(div_vld),
		.quo_out(div_quo),
		.pay_out(div_pay)
	);

	// Stage 4: y0 * (1.0 - c) and y1 * c.
	logic [VB-1:0]     y0;
	logic [VB-1:0]     y1;
	logic [FRAC_W-1:0] c;
	logic [FRAC_W:0]   w0;
	assign y0 = div_pay[VB-1:0];
	assign y1 = div_pay[2*VB-1:VB];
	assign c = div_pay[2*VB] ? '0 : div_quo;
	assign w0 = {1'b1, {FRAC_W{1'b0}}} - {1'b0, c};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s4 <= div_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ns_s4 <= div_pay[2*VB+1];
			p0_s4 <= MW'(y0) * MW'(w0);
			p1_s4 <= MW'(y1) * MW'(c);
		end
	end

	// Output stage: sum, drop the fraction and undo the bias.
	logic [MW-1:0] acc;
	assign acc = p0_s4 + p1_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (en) begin
			out_vld_q <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_ns_q <= ns_s4;
			out_val_q <= ns_s4 ? '0 :
				(acc[FRAC_W +: VB] ^ {1'b1, {(VB-1){1'b0}}});
		end
	end

	logic [VB+OUT_DATA_W-1:0] out_ext;
	assign out_ext = {{OUT_DATA_W{1'b0}}, out_val_q};
	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata = out_ext[OUT_DATA_W-1:0];
	assign m_axis_tuser = out_ns_q;

`ifndef NO_ASSERTIONS
	// A word flagged as having no segment carries a zero value.
	a_noseg_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata == '0)
		else $error("no_segment word with nonzero value");

	// A new output word comes only from a product stage that held one.
	a_out_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(v_s4))
		else $error("output word without a source in the product stage");

	// The stored last index never falls below one, so at least two breakpoints are in use.
	a_last_range: assert property (@(posedge clk) disable iff (!arst_n)
		last_q >= IW'(1))
		else $error("last breakpoint index below one");
`endif

endmodule
